// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked at every rising edge outside reset.
`define FENV_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Condition in one cycle requires an outcome in the next cycle.
`define FENV_ASSERT_NEXT(lbl, clk, rstn, cond, outcome, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (outcome)) \
        else $error(msg);

`endif

// ===== sv/fenv_pkg.sv =====
// ----------------------------------------------------------------------------
// fenv_pkg
// Shared types and constants of the flash environment record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fenv_pkg;

    localparam int MAX_REGION = 65536;
    localparam int POS_W      = 17;
    localparam int ID_W       = 7;
    localparam int ID_DEPTH   = 1 << ID_W;
    localparam int CNT_W      = 8;
    localparam int EPOCH_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int OUT_W      = 64;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [EPOCH_W-1:0] t_epoch;

    localparam t_pos   POS_MAX     = '1;
    localparam t_epoch EPOCH_MAX   = '1;
    localparam t_epoch EPOCH_FIRST = t_epoch'(1);

    localparam logic [7:0] BYTE_ERASED = 8'hFF;
    localparam logic [7:0] BYTE_NUL    = 8'h00;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LENGTH = 2'd2;

    localparam logic [7:0]       MAGIC_FIRST_RST   = 8'd65;
    localparam logic [7:0]       MAGIC_SECOND_RST  = 8'd101;
    localparam logic [POS_W-1:0] REGION_LENGTH_RST = 17'd65536;

    typedef enum logic [5:0] {
        PH_MAGIC1 = 6'b000001,
        PH_MAGIC2 = 6'b000010,
        PH_RECORD = 6'b000100,
        PH_KEY    = 6'b001000,
        PH_VALUE  = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_EMPTY   = 3'd1,
        EV_UNRECOG = 3'd2,
        EV_KEY     = 3'd3,
        EV_ACTIVE  = 3'd4,
        EV_ERASED  = 3'd5,
        EV_END     = 3'd6
    } t_event;

    // packed so that event_res lands in the lowest bits of tdata
    typedef struct packed {
        logic [CNT_W-1:0] unique_ids;
        logic [CNT_W-1:0] next_free_id;
        t_pos             text_offset;
        t_pos             record_offset;
        logic [ID_W-1:0]  entry_id;
        t_event           event_res;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/fenv_ram.sv =====
// ----------------------------------------------------------------------------
// fenv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fenv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/flash_env_record_parser.sv =====
// ----------------------------------------------------------------------------
// flash_env_record_parser
// Byte-serial parser of a flash environment region with a seen-id memory.
// ----------------------------------------------------------------------------
// Takes one region byte per cycle while the output is not stalled and no clearing pass
// runs, and returns one result item per byte, through the registered seen-id memory
// read and then the parse update into the output register. The seen-id map is a
// 128-entry RAM tagged with a restart epoch, so a restart does not touch the RAM;
// after reset, and after every 255th restart when the epoch wraps, a clearing pass
// runs through the RAM, one entry per cycle on its single write port, with
// s_axis_tready low. Configuration writes are taken at any time.
`default_nettype none

module flash_env_record_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // tdata: data_byte[7:0]
    input  wire logic [7:0]                       s_axis_tdata,
    // tuser: first_byte[0]
    input  wire logic [0:0]                       s_axis_tuser,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: event_res[2:0], entry_id[9:3], record_offset[26:10],
    //        text_offset[43:27], next_free_id[51:44], unique_ids[59:52], zero[63:60]
    output logic [fenv_pkg::OUT_W-1:0]            m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             i_cfg_we,
    input  wire logic [fenv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fenv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import fenv_pkg::*;

    // configuration
    logic [7:0] r_magic_first;
    logic [7:0] r_magic_second;
    t_pos       r_region_len;

    // clearing pass and epoch
    logic            r_clr_busy;
    logic [ID_W-1:0] r_clr_addr;
    t_epoch          r_epoch;

    // read stage
    logic       r_s1_vld;
    logic [7:0] r_s1_byte;
    logic       r_s1_first;
    t_epoch     r_s1_epoch;
    logic       r_fwd_hit;
    t_epoch     r_fwd_data;

    // parse state
    t_phase           r_phase,   n_phase;
    logic [CNT_W-1:0] r_hn,      n_hn;
    logic [CNT_W-1:0] r_dc,      n_dc;
    t_pos             r_pos,     n_pos;
    t_pos             r_rec,     n_rec;
    t_pos             r_str,     n_str;
    logic [ID_W-1:0]  r_cid,     n_cid;
    logic             r_cvld,    n_cvld;
    logic [7:0]       r_fm,      n_fm;

    // output register
    logic    r_out_vld;
    t_result r_out;
    t_result s1_res;

    logic             advance;
    logic             in_acc;
    logic             s1_do;
    logic             s1_wr;
    logic             seen;
    t_epoch           ram_rdata;
    logic             ram_we;
    logic [ID_W-1:0]  ram_waddr;
    t_epoch           ram_wdata;
    t_pos             pos_inc;
    t_pos             len_clamp;
    logic [POS_W:0]   lim_end;

    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = advance && !r_clr_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s1_do         = advance && r_s1_vld;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

    // ---------------- seen-id memory ----------------
    assign ram_we    = r_clr_busy || (s1_do && s1_wr);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_byte[ID_W-1:0];
    assign ram_wdata = r_clr_busy ? '0 : r_s1_epoch;

    fenv_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (ID_DEPTH)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc),
        .i_raddr (s_axis_tdata[ID_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign seen = ((r_fwd_hit ? r_fwd_data : ram_rdata) == r_s1_epoch);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic_first  <= MAGIC_FIRST_RST;
            r_magic_second <= MAGIC_SECOND_RST;
            r_region_len   <= REGION_LENGTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAGIC_FIRST:   r_magic_first  <= i_cfg_data[7:0];
                CFG_MAGIC_SECOND:  r_magic_second <= i_cfg_data[7:0];
                CFG_REGION_LENGTH: r_region_len   <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- clearing pass, epoch, read stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
            r_s1_vld   <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ID_W'(ID_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (in_acc && s_axis_tuser[0]) begin
                if (r_epoch == EPOCH_MAX) begin
                    r_epoch    <= EPOCH_FIRST;
                    r_clr_busy <= 1'b1;
                    r_clr_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
            if (advance) begin
                r_s1_vld  <= in_acc;
                r_fwd_hit <= s1_do && s1_wr && in_acc
                             && (s_axis_tdata[ID_W-1:0] == r_s1_byte[ID_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_byte  <= s_axis_tdata;
            r_s1_first <= s_axis_tuser[0];
            r_s1_epoch <= r_epoch;
            r_fwd_data <= r_s1_epoch;
        end
    end

    // ---------------- parse update ----------------
    assign pos_inc   = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    assign len_clamp = ({15'd0, r_region_len} > 32'(MAX_REGION)) ? POS_W'(MAX_REGION)
                                                                 : r_region_len;
    assign lim_end   = {1'b0, len_clamp} + (POS_W+1)'(2);

    always_comb begin
        n_phase = r_phase;
        n_hn    = r_hn;
        n_dc    = r_dc;
        n_pos   = r_pos;
        n_rec   = r_rec;
        n_str   = r_str;
        n_cid   = r_cid;
        n_cvld  = r_cvld;
        n_fm    = r_fm;
        s1_wr   = 1'b0;
        s1_res  = '0;
        s1_res.event_res = EV_NONE;

        if (r_s1_first) begin
            n_hn    = '0;
            n_dc    = '0;
            n_pos   = POS_W'(1);
            n_rec   = '0;
            n_str   = '0;
            n_cid   = '0;
            n_cvld  = 1'b0;
            n_fm    = r_s1_byte;
            n_phase = PH_MAGIC2;
        end else begin
            case (r_phase)
                PH_MAGIC2: begin
                    if (r_fm == BYTE_ERASED && r_s1_byte == BYTE_ERASED) begin
                        s1_res.event_res = EV_EMPTY;
                        n_phase          = PH_DONE;
                    end else if (r_fm == r_magic_first && r_s1_byte == r_magic_second) begin
                        n_phase = PH_RECORD;
                        n_pos   = pos_inc;
                    end else begin
                        s1_res.event_res = EV_UNRECOG;
                        n_phase          = PH_DONE;
                    end
                end
                PH_RECORD: begin
                    if ({1'b0, r_pos} >= lim_end || r_s1_byte == BYTE_ERASED) begin
                        s1_res.event_res = EV_END;
                        n_phase          = PH_DONE;
                    end else begin
                        n_cid  = r_s1_byte[ID_W-1:0];
                        n_cvld = r_s1_byte[7];
                        n_rec  = r_pos;
                        n_str  = pos_inc;
                        if ({1'b0, r_s1_byte[ID_W-1:0]} >= r_hn) begin
                            n_hn = {1'b0, r_s1_byte[ID_W-1:0]} + 1'b1;
                        end
                        if (!seen) begin
                            s1_wr   = 1'b1;
                            n_dc    = r_dc + 1'b1;
                            n_phase = PH_KEY;
                        end else begin
                            n_phase = PH_VALUE;
                        end
                        n_pos = pos_inc;
                    end
                end
                PH_KEY: begin
                    if (r_s1_byte == BYTE_NUL) begin
                        s1_res.event_res     = EV_KEY;
                        s1_res.entry_id      = r_cid;
                        s1_res.record_offset = r_rec;
                        s1_res.text_offset   = r_str;
                        n_str                = pos_inc;
                        n_phase              = PH_VALUE;
                    end
                    n_pos = pos_inc;
                end
                PH_VALUE: begin
                    if (r_s1_byte == BYTE_NUL) begin
                        s1_res.event_res     = r_cvld ? EV_ACTIVE : EV_ERASED;
                        s1_res.entry_id      = r_cid;
                        s1_res.record_offset = r_rec;
                        s1_res.text_offset   = r_str;
                        n_phase              = PH_RECORD;
                    end
                    n_pos = pos_inc;
                end
                default: ;
            endcase
        end

        s1_res.next_free_id = n_hn;
        s1_res.unique_ids   = n_dc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC1;
            r_hn      <= '0;
            r_dc      <= '0;
            r_pos     <= '0;
            r_rec     <= '0;
            r_str     <= '0;
            r_cid     <= '0;
            r_cvld    <= 1'b0;
            r_fm      <= '0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_phase <= n_phase;
                r_hn    <= n_hn;
                r_dc    <= n_dc;
                r_pos   <= n_pos;
                r_rec   <= n_rec;
                r_str   <= n_str;
                r_cid   <= n_cid;
                r_cvld  <= n_cvld;
                r_fm    <= n_fm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_do) begin
            r_out <= s1_res;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fenv_checker.sv =====
// ----------------------------------------------------------------------------
// fenv_checker
// Port-level checks of the flash environment record parser.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fenv_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic [fenv_pkg::OUT_W-1:0]    m_axis_tdata,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready
);

    import fenv_pkg::*;

    t_result res;

    assign res = m_axis_tdata[$bits(t_result)-1:0];

    `FENV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result item dropped or changed while stalled")

    `FENV_ASSERT(a_uid_le_nfi, i_clk, i_rst_n, m_axis_tvalid |-> (res.unique_ids <= res.next_free_id), "distinct id count above next free id")

    `FENV_ASSERT(a_nfi_range, i_clk, i_rst_n, m_axis_tvalid |-> (res.next_free_id <= 8'd128), "next free id out of range")

    `FENV_ASSERT(a_key_offset, i_clk, i_rst_n, m_axis_tvalid && res.event_res == EV_KEY |-> (res.text_offset == res.record_offset + 1'b1), "key does not start right after its id byte")

    `FENV_ASSERT(a_no_record_fields, i_clk, i_rst_n, m_axis_tvalid && (res.event_res == EV_NONE || res.event_res == EV_EMPTY || res.event_res == EV_UNRECOG || res.event_res == EV_END) |-> (res.entry_id == '0 && res.record_offset == '0 && res.text_offset == '0), "record fields set on a non-record event")

endmodule

bind flash_env_record_parser fenv_checker u_fenv_checker (.*);

`default_nettype wire
